[hw/rtl/lsmc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsmc_pkg
// Shared constants, register indexes, mode codes and structs of the
// light servo mode controller.
// ----------------------------------------------------------------------------
package lsmc_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int DUTY_BITS_DEF   = 13;

  localparam int ANGLE_W   = 8;
  localparam int HELD_W    = 12;
  localparam int DEB_W     = 8;
  localparam int BLINK_W   = 8;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 3;

  localparam logic [ANGLE_W-1:0] FULL_ANGLE = 8'd180;
  localparam logic [HELD_W-1:0]  HELD_MAX   = 12'd4095;
  localparam logic [BLINK_W-1:0] COUNT_MAX  = 8'd255;

  localparam logic [MODE_W-1:0] MODE_AUTO   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLOSED = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OPEN   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DUTY   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CEIL_DUTY  = 3'd4;

  localparam logic [DEB_W-1:0]   DEBOUNCE_RESET   = 8'd2;
  localparam logic [HELD_W-1:0]  LONG_PRESS_RESET = 12'd100;
  localparam logic [BLINK_W-1:0] BLINK_RESET      = 8'd8;
  localparam int                 MIN_DUTY_RESET   = 410;
  localparam int                 CEIL_DUTY_RESET  = 1024;

  typedef struct packed {
    logic [DEB_W-1:0]   debounce_count;
    logic [HELD_W-1:0]  long_press_count;
    logic [BLINK_W-1:0] blink_period;
  } ctrl_cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic               short_press;
    logic               long_press;
    logic [ANGLE_W-1:0] angle;
    logic               moved;
    logic               green;
    logic               red;
    logic               yellow;
  } tick_res_t;

endpackage
`default_nettype wire

[hw/rtl/lsmc_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsmc_ctrl
// Per-tick state update: button recognizer, mode machine, light filter and
// target, one-degree servo step and yellow blink.
// ----------------------------------------------------------------------------
module lsmc_ctrl #(
  parameter int SAMPLE_BITS = lsmc_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   tick_en,
  input  wire logic                   button_down,
  input  wire logic                   sample_valid,
  input  wire logic [SAMPLE_BITS-1:0] light_sample,
  input  wire lsmc_pkg::ctrl_cfg_t    cfg,
  output lsmc_pkg::tick_res_t         res
);
  import lsmc_pkg::*;

  localparam int FILT_W = SAMPLE_BITS + 3;
  localparam int PROD_W = SAMPLE_BITS + ANGLE_W + 1;
  localparam logic [SAMPLE_BITS-1:0] FILT_RESET = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic [HELD_W-1:0]      held_r, held_nxt, held_inc;
  logic                   long_rep_r, long_rep_nxt;
  logic [MODE_W-1:0]      mode_r, mode_nxt;
  logic [SAMPLE_BITS-1:0] filt_r, filt_nxt, filt_calc;
  logic [ANGLE_W-1:0]     target_r, target_nxt, target_calc;
  logic [ANGLE_W-1:0]     angle_r, angle_nxt;
  logic [BLINK_W-1:0]     tick_cnt_r, tick_cnt_nxt, tick_cnt_inc;
  logic                   yellow_r, yellow_nxt;
  logic                   short_p, long_p, moved;
  logic [FILT_W-1:0]      filt_sum;
  logic [PROD_W-1:0]      scaled, quot_sum;

  assign held_inc     = (held_r < HELD_MAX) ? held_r + 1'b1 : held_r;
  assign tick_cnt_inc = (tick_cnt_r < COUNT_MAX) ? tick_cnt_r + 1'b1 : tick_cnt_r;

  // filter*7 + sample, then divide by 8
  assign filt_sum  = FILT_W'({filt_r, 3'b000}) - FILT_W'(filt_r) + FILT_W'(light_sample);
  assign filt_calc = filt_sum[FILT_W-1:3];

  // filter*180 / (2^n - 1), exact since the quotient stays below 2^n
  assign scaled      = PROD_W'(filt_calc) * PROD_W'(FULL_ANGLE);
  assign quot_sum    = scaled + (scaled >> SAMPLE_BITS) + PROD_W'(1);
  assign target_calc = quot_sum[SAMPLE_BITS +: ANGLE_W];

  always_comb begin
    held_nxt     = held_r;
    long_rep_nxt = long_rep_r;
    short_p      = 1'b0;
    long_p       = 1'b0;
    if (button_down) begin
      held_nxt = held_inc;
      if (held_inc >= cfg.long_press_count && !long_rep_r) begin
        long_p       = 1'b1;
        long_rep_nxt = 1'b1;
      end
    end else begin
      short_p      = (held_r >= HELD_W'(cfg.debounce_count)) && !long_rep_r;
      held_nxt     = '0;
      long_rep_nxt = 1'b0;
    end

    mode_nxt = mode_r;
    if (long_p) begin
      mode_nxt = (mode_r == MODE_AUTO) ? MODE_OPEN : MODE_AUTO;
    end else if (short_p) begin
      if (mode_r == MODE_OPEN) begin
        mode_nxt = MODE_CLOSED;
      end else if (mode_r == MODE_CLOSED) begin
        mode_nxt = MODE_OPEN;
      end
    end

    filt_nxt   = filt_r;
    target_nxt = target_r;
    if (mode_nxt == MODE_AUTO) begin
      if (sample_valid) begin
        filt_nxt   = filt_calc;
        target_nxt = target_calc;
      end
    end else if (mode_nxt == MODE_CLOSED) begin
      target_nxt = '0;
    end else begin
      target_nxt = FULL_ANGLE;
    end

    tick_cnt_nxt = tick_cnt_inc;
    yellow_nxt   = yellow_r;
    angle_nxt    = angle_r;
    moved        = 1'b0;
    if (angle_r != target_nxt) begin
      moved     = 1'b1;
      angle_nxt = (angle_r < target_nxt) ? angle_r + 1'b1 : angle_r - 1'b1;
      if (tick_cnt_inc >= cfg.blink_period) begin
        tick_cnt_nxt = '0;
        yellow_nxt   = !yellow_r;
      end
    end else begin
      yellow_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r     <= '0;
      long_rep_r <= 1'b0;
      mode_r     <= MODE_AUTO;
      filt_r     <= FILT_RESET;
      target_r   <= FULL_ANGLE;
      angle_r    <= FULL_ANGLE;
      tick_cnt_r <= '0;
      yellow_r   <= 1'b0;
    end else if (tick_en) begin
      held_r     <= held_nxt;
      long_rep_r <= long_rep_nxt;
      mode_r     <= mode_nxt;
      filt_r     <= filt_nxt;
      target_r   <= target_nxt;
      angle_r    <= angle_nxt;
      tick_cnt_r <= tick_cnt_nxt;
      yellow_r   <= yellow_nxt;
    end
  end

  always_comb begin
    res.mode        = mode_nxt;
    res.short_press = short_p;
    res.long_press  = long_p;
    res.angle       = angle_nxt;
    res.moved       = moved;
    res.green       = (mode_nxt == MODE_AUTO);
    res.red         = (mode_nxt != MODE_AUTO);
    res.yellow      = yellow_nxt;
  end

`ifndef ASSERT_OFF
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    angle_r <= FULL_ANGLE)
    else $error("servo angle beyond full range");

  a_angle_step: assert property (@(posedge clk) disable iff (!rst_n)
    tick_en |=> (angle_r == $past(angle_r)) || (angle_r == $past(angle_r) + 8'd1) ||
                (angle_r == $past(angle_r) - 8'd1))
    else $error("servo angle moved more than one degree");

  a_long_toggles: assert property (@(posedge clk) disable iff (!rst_n)
    tick_en && long_p |=> (mode_r == MODE_AUTO) != ($past(mode_r) == MODE_AUTO))
    else $error("long press did not toggle auto mode");
`endif

endmodule
`default_nettype wire

[hw/rtl/lsmc_duty.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsmc_duty
// Two-stage duty pipeline: span times angle, then divide by 180 through a
// reciprocal multiply and add the minimum duty.
// ----------------------------------------------------------------------------
module lsmc_duty #(
  parameter int DUTY_BITS = lsmc_pkg::DUTY_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         prod_en,
  input  wire logic                         duty_en,
  input  wire logic [lsmc_pkg::ANGLE_W-1:0] angle,
  input  wire logic [DUTY_BITS-1:0]         min_duty,
  input  wire logic [DUTY_BITS-1:0]         ceil_duty,
  output logic      [DUTY_BITS-1:0]         duty
);
  import lsmc_pkg::*;

  localparam int P_W         = DUTY_BITS + ANGLE_W;
  localparam int RECIP_SHIFT = DUTY_BITS + 16;
  localparam int RECIP_W     = RECIP_SHIFT - 7;
  localparam int RP_W        = P_W + RECIP_W;
  localparam logic [RECIP_SHIFT:0] POW_K = {1'b1, {RECIP_SHIFT{1'b0}}};
  localparam logic [RECIP_SHIFT:0] RECIP_FULL =
    (POW_K + (RECIP_SHIFT+1)'(FULL_ANGLE - 8'd1)) / (RECIP_SHIFT+1)'(FULL_ANGLE);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

  logic [DUTY_BITS-1:0] span;
  logic [P_W-1:0]       prod_r;
  logic [RP_W-1:0]      recip_prod;
  logic [DUTY_BITS-1:0] quot;
  logic [DUTY_BITS-1:0] duty_r;

  assign span       = (ceil_duty > min_duty) ? ceil_duty - min_duty : '0;
  assign recip_prod = RP_W'(prod_r) * RP_W'(RECIP);
  assign quot       = recip_prod[RECIP_SHIFT +: DUTY_BITS];

  always_ff @(posedge clk) begin
    if (prod_en) begin
      prod_r <= P_W'(span) * P_W'(angle);
    end
    if (duty_en) begin
      duty_r <= min_duty + quot;
    end
  end

  assign duty = duty_r;

endmodule
`default_nettype wire

[hw/rtl/light_servo_mode_controller_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// light_servo_mode_controller_core
// Light-following servo with single-button mode switch, one word per tick.
// ----------------------------------------------------------------------------
// One input word is one control tick and gives one result word. The block
// takes one word per clock cycle sustained while out_ready is high; a result
// passes the input register, the tick state update, the span-angle product,
// the reciprocal divide and the output register before it is presented. The
// tick state update in lsmc_ctrl closes the loop from one word to the next;
// each stage holds while the stage after it is full, so the pipe fills up to
// four words before in_ready drops. No memory, no clearing pass after reset.
module light_servo_mode_controller_core #(
  parameter int SAMPLE_BITS = lsmc_pkg::SAMPLE_BITS_DEF,
  parameter int DUTY_BITS   = lsmc_pkg::DUTY_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_button_down,
  input  wire logic                           in_sample_valid,
  input  wire logic [SAMPLE_BITS-1:0]         in_light_sample,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [lsmc_pkg::MODE_W-1:0]         out_mode,
  output logic                                out_short_press,
  output logic                                out_long_press,
  output logic [lsmc_pkg::ANGLE_W-1:0]        out_servo_angle,
  output logic [DUTY_BITS-1:0]                out_servo_duty,
  output logic                                out_servo_updated,
  output logic                                out_green_led,
  output logic                                out_red_led,
  output logic                                out_yellow_led,
  input  wire logic                           cfg_we,
  input  wire logic [lsmc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [((DUTY_BITS > lsmc_pkg::HELD_W) ? DUTY_BITS : lsmc_pkg::HELD_W)-1:0]
                                              cfg_wdata
);
  import lsmc_pkg::*;

  ctrl_cfg_t            ctrl_cfg_r;
  logic [DUTY_BITS-1:0] min_duty_r, ceil_duty_r;

  logic                   v0_r, v1_r, v2_r, v3_r;
  logic                   en1, en2, en3, in_acc;
  logic                   down_r, svalid_r;
  logic [SAMPLE_BITS-1:0] sample_r;
  tick_res_t              tick_res, res1_r, res2_r, res3_r;
  logic [DUTY_BITS-1:0]   duty;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_cfg_r.debounce_count   <= DEBOUNCE_RESET;
      ctrl_cfg_r.long_press_count <= LONG_PRESS_RESET;
      ctrl_cfg_r.blink_period     <= BLINK_RESET;
      min_duty_r                  <= DUTY_BITS'(MIN_DUTY_RESET);
      ceil_duty_r                 <= DUTY_BITS'(CEIL_DUTY_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE:   ctrl_cfg_r.debounce_count   <= cfg_wdata[DEB_W-1:0];
        REG_LONG_PRESS: ctrl_cfg_r.long_press_count <= cfg_wdata[HELD_W-1:0];
        REG_BLINK:      ctrl_cfg_r.blink_period     <= cfg_wdata[BLINK_W-1:0];
        REG_MIN_DUTY:   min_duty_r                  <= cfg_wdata[DUTY_BITS-1:0];
        REG_CEIL_DUTY:  ceil_duty_r                 <= cfg_wdata[DUTY_BITS-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  assign en3      = v2_r && (!v3_r || out_ready);
  assign en2      = v1_r && (!v2_r || en3);
  assign en1      = v0_r && (!v1_r || en2);
  assign in_ready = !v0_r || en1;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v0_r <= in_acc || (v0_r && !en1);
      v1_r <= en1 || (v1_r && !en2);
      v2_r <= en2 || (v2_r && !en3);
      v3_r <= en3 || (v3_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      down_r   <= in_button_down;
      svalid_r <= in_sample_valid;
      sample_r <= in_light_sample;
    end
    if (en1) begin
      res1_r <= tick_res;
    end
    if (en2) begin
      res2_r <= res1_r;
    end
    if (en3) begin
      res3_r <= res2_r;
    end
  end

  lsmc_ctrl #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .tick_en      (en1),
    .button_down  (down_r),
    .sample_valid (svalid_r),
    .light_sample (sample_r),
    .cfg          (ctrl_cfg_r),
    .res          (tick_res)
  );

  lsmc_duty #(
    .DUTY_BITS (DUTY_BITS)
  ) u_duty (
    .clk       (clk),
    .prod_en   (en2),
    .duty_en   (en3),
    .angle     (res1_r.angle),
    .min_duty  (min_duty_r),
    .ceil_duty (ceil_duty_r),
    .duty      (duty)
  );

  assign out_valid         = v3_r;
  assign out_mode          = res3_r.mode;
  assign out_short_press   = res3_r.short_press;
  assign out_long_press    = res3_r.long_press;
  assign out_servo_angle   = res3_r.angle;
  assign out_servo_duty    = duty;
  assign out_servo_updated = res3_r.moved;
  assign out_green_led     = res3_r.green;
  assign out_red_led       = res3_r.red;
  assign out_yellow_led    = res3_r.yellow;

`ifndef ASSERT_OFF
  a_press_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_short_press && out_long_press))
    else $error("short and long press in one word");

  a_led_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_green_led != out_red_led) &&
                  (out_green_led == (out_mode == MODE_AUTO)))
    else $error("mode leds disagree with mode");

  a_yellow_still: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_servo_updated |-> !out_yellow_led)
    else $error("yellow lit while servo at target");
`endif

endmodule
`default_nettype wire
